>>> sv/yxfw_pkg.sv
// shared types and constants for the yuyv to xrgb framebuffer writer
package yxfw_pkg;

    // geometry limits
    localparam logic [11:0] MAX_LINE_PAIRS = 12'd2048;
    localparam logic [11:0] MAX_LINES      = 12'd2048;

    // register reset values
    localparam logic [11:0] PAIRS_RESET  = 12'd320;
    localparam logic [11:0] LINES_RESET  = 12'd480;
    localparam logic [12:0] STRIDE_RESET = 13'd1024;

    // q16 conversion coefficients
    localparam logic signed [17:0] COEF_RV = 18'sd91881;
    localparam logic signed [17:0] COEF_GU = 18'sd22544;
    localparam logic signed [17:0] COEF_GV = 18'sd46793;
    localparam logic signed [17:0] COEF_BU = 18'sd116130;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // register word index on the config port
    typedef enum logic [1:0] {
        REG_PAIRS_PER_LINE  = 2'd0,
        REG_LINES_PER_FRAME = 2'd1,
        REG_LINE_STRIDE     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } in_beat_t;

    typedef struct packed {
        logic [23:0] pixel_addr;
        logic [31:0] pixel_first;
        logic [31:0] pixel_second;
        logic        line_end;
        logic        frame_end;
    } out_beat_t;

    typedef struct packed {
        logic [11:0] pairs_per_line;
        logic [11:0] lines_per_frame;
        logic [12:0] line_stride;
    } cfg_t;

    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic        line_end;
        logic        frame_end;
    } scan_pos_t;

endpackage

>>> sv/yxfw_regs.sv
// apb register file holding the frame geometry
module yxfw_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output yxfw_pkg::cfg_t    cfg
);
    import yxfw_pkg::*;

    logic [11:0] pairs_reg;
    logic [11:0] lines_reg;
    logic [12:0] stride_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg  <= PAIRS_RESET;
            lines_reg  <= LINES_RESET;
            stride_reg <= STRIDE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PAIRS_PER_LINE:  pairs_reg  <= pwdata[11:0];
                REG_LINES_PER_FRAME: lines_reg  <= pwdata[11:0];
                REG_LINE_STRIDE:     stride_reg <= pwdata[12:0];
                default:             ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_PAIRS_PER_LINE:  prdata = {20'd0, pairs_reg};
            REG_LINES_PER_FRAME: prdata = {20'd0, lines_reg};
            REG_LINE_STRIDE:     prdata = {19'd0, stride_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.pairs_per_line  = pairs_reg;
    assign cfg.lines_per_frame = lines_reg;
    assign cfg.line_stride     = stride_reg;

endmodule

>>> sv/yxfw_scan.sv
// column and row counters with line and frame end flags
module yxfw_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  yxfw_pkg::cfg_t       cfg,
    output yxfw_pkg::scan_pos_t  pos
);
    import yxfw_pkg::*;

    logic [10:0] column_reg, column_next;
    logic [10:0] row_reg, row_next;
    logic [11:0] cols_eff, rows_eff;
    logic [11:0] col_inc, row_inc;
    logic        last_col, last_row;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        priority if (cfg.pairs_per_line == 12'd0)
            cols_eff = 12'd1;
        else if (cfg.pairs_per_line > MAX_LINE_PAIRS)
            cols_eff = MAX_LINE_PAIRS;
        else
            cols_eff = cfg.pairs_per_line;

        priority if (cfg.lines_per_frame == 12'd0)
            rows_eff = 12'd1;
        else if (cfg.lines_per_frame > MAX_LINES)
            rows_eff = MAX_LINES;
        else
            rows_eff = cfg.lines_per_frame;
    end

    // end detection, also catches counters left past a shrunk limit
    assign col_inc  = {1'b0, column_reg} + 12'd1;
    assign row_inc  = {1'b0, row_reg} + 12'd1;
    assign last_col = col_inc >= cols_eff;
    assign last_row = row_inc >= rows_eff;

    // counter advance on each accepted beat
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (step)
        begin
            if (last_col)
            begin
                column_next = 11'd0;
                row_next    = last_row ? 11'd0 : row_inc[10:0];
            end
            else
            begin
                column_next = col_inc[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 11'd0;
            row_reg    <= 11'd0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign pos.column    = column_reg;
    assign pos.row       = row_reg;
    assign pos.line_end  = last_col;
    assign pos.frame_end = last_col && last_row;

    // a line end always returns the column to zero
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_col |=> column_reg == 11'd0)
        else $error("column did not wrap at line end");

    // inside a line the row holds and the column steps by one
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_col |=> column_reg == $past(column_reg) + 11'd1
                              && row_reg == $past(row_reg))
        else $error("column step wrong inside line");

endmodule

>>> sv/yxfw_pixel_conv.sv
// one yuv sample to an xrgb8888 word, bt.601 full range in q16
module yxfw_pixel_conv (
    input  logic [7:0]  luma,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    output logic [31:0] pixel
);
    import yxfw_pkg::*;

    logic signed [7:0]  u_s, v_s;
    logic signed [27:0] yq;
    logic signed [27:0] prod_rv, prod_gu, prod_gv, prod_bu;
    logic signed [27:0] r_q, g_q, b_q;

    // remove the 128 offset by flipping the top bit
    assign u_s = {~chroma_blue[7], chroma_blue[6:0]};
    assign v_s = {~chroma_red[7], chroma_red[6:0]};
    assign yq  = {4'd0, luma, 16'd0};

    assign prod_rv = 28'(COEF_RV) * 28'(v_s);
    assign prod_gu = 28'(COEF_GU) * 28'(u_s);
    assign prod_gv = 28'(COEF_GV) * 28'(v_s);
    assign prod_bu = 28'(COEF_BU) * 28'(u_s);

    assign r_q = yq + prod_rv;
    assign g_q = yq - prod_gu - prod_gv;
    assign b_q = yq + prod_bu;

    // divide by 65536 toward zero, keep the low byte
    function automatic logic [7:0] q16_byte(input logic signed [27:0] q);
        logic round_up;
        round_up = q[27] && (q[15:0] != 16'd0);
        return q[23:16] + {7'd0, round_up};
    endfunction

    assign pixel = {ALPHA_OPAQUE, q16_byte(r_q), q16_byte(g_q), q16_byte(b_q)};

endmodule

>>> sv/yuyv_to_xrgb_framebuffer_writer.sv
// top level: yuyv macropixel to two xrgb8888 framebuffer words
//
// Input channel in_valid/in_ready/in_data carries one YUYV macropixel per
// beat. Output channel out_valid/out_ready/out_data carries the two XRGB8888
// words of that pair (alpha 0xFF), the framebuffer pixel index of the first
// word (row * line_stride + 2 * column, mod 2^24) and the line and frame end
// flags. Exactly one output beat follows every input beat, in order.
// The APB port sets pairs_per_line (0x0), lines_per_frame (0x4) and
// line_stride (0x8); write it only while no beat is in flight.
// An accepted input beat is loaded into the input register and then into the
// result register, which drives the output beat. Throughput: one macropixel
// per cycle while out_ready stays high, with the two register stages (input
// register, result register) around the combinational color conversion and
// address multiply.
// Reset clears the pipeline and the scan counters and loads 320 pairs,
// 480 lines and a stride of 1024. When out_ready is low the result register
// holds, the input register fills, and then in_ready drops; nothing is lost.
module yuyv_to_xrgb_framebuffer_writer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  yxfw_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output yxfw_pkg::out_beat_t   out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import yxfw_pkg::*;

    cfg_t      cfg;
    scan_pos_t pos;
    logic      accept;
    logic      out_load;
    logic      s1_move;

    logic      s1_valid_reg, s1_valid_next;
    in_beat_t  s1_beat_reg;
    scan_pos_t s1_pos_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg, out_data_next;

    logic [23:0] row_offset;
    logic [31:0] pix_first, pix_second;

    yxfw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    yxfw_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .cfg   (cfg),
        .pos   (pos)
    );

    // pipeline flow control
    assign out_load = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register: beat plus its scan position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg <= in_data;
            s1_pos_reg  <= pos;
        end
    end

    // color conversion of both pixels
    yxfw_pixel_conv u_conv_first (
        .luma        (s1_beat_reg.luma_first),
        .chroma_blue (s1_beat_reg.chroma_blue),
        .chroma_red  (s1_beat_reg.chroma_red),
        .pixel       (pix_first)
    );

    yxfw_pixel_conv u_conv_second (
        .luma        (s1_beat_reg.luma_second),
        .chroma_blue (s1_beat_reg.chroma_blue),
        .chroma_red  (s1_beat_reg.chroma_red),
        .pixel       (pix_second)
    );

    // framebuffer address
    assign row_offset = {13'd0, s1_pos_reg.row} * {11'd0, cfg.line_stride};

    always_comb
    begin
        out_data_next.pixel_addr   = row_offset + {12'd0, s1_pos_reg.column, 1'b0};
        out_data_next.pixel_first  = pix_first;
        out_data_next.pixel_second = pix_second;
        out_data_next.line_end     = s1_pos_reg.line_end;
        out_data_next.frame_end    = s1_pos_reg.frame_end;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a frame end is always also a line end
    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !out_data_reg.frame_end || out_data_reg.line_end)
        else $error("frame end without line end");

    // a stalled input register keeps its beat
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_beat_reg)
                                      && $stable(s1_pos_reg))
        else $error("input register lost a stalled beat");

    // an empty input register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with empty pipeline");

    // a beat in the input register reaches the output once it is free
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_load |=> out_valid_reg)
        else $error("beat did not advance to result register");

endmodule
